[sv/lvf_pkg.sv]
// ============================================================================
// lvf_pkg
// Shared types and constants of the LED video USB packet framer.
// ============================================================================
`default_nettype none

package lvf_pkg;

   // Packet geometry
   localparam int PKT_BYTES = 64;
   localparam logic [4:0] LEDS_PER_PKT = 5'((PKT_BYTES - 1) / 3);
   localparam logic [5:0] LAST_OFFSET = 6'(PKT_BYTES - 1);

   // Control byte codes
   localparam logic [7:0] VIDEO_TYPE = 8'h00;
   localparam logic [7:0] FINAL_BIT = 8'h20;
   localparam logic [7:0] PAD_BYTE = 8'h00;

   // Job queue between front and back
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;

   // One classified LED, ready for byte emission
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       open_pkt;   // emit the control byte first
      logic [7:0] ctrl_byte;
      logic [5:0] base_off;   // offset of the red byte
      logic       pad;        // close the packet after this LED
      logic       last_slot;  // last slot of the frame
   } lvf_job_type;

endpackage

`default_nettype wire

[sv/lvf_front.sv]
// ============================================================================
// lvf_front
// Accepts LED items, tracks slot, packet and LED-in-packet counters and
// turns each item into one job for the byte emitter.
// ============================================================================
`default_nettype none

module lvf_front #(
   parameter int STRIP_COUNT = 8,
   parameter int STRIP_LENGTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_red,
   input  wire logic [7:0]           req_green,
   input  wire logic [7:0]           req_blue,
   input  wire logic                 q_full,
   output logic                      push,
   output lvf_pkg::lvf_job_type      job
);
   import lvf_pkg::*;

   localparam int TotalSlots = STRIP_COUNT * STRIP_LENGTH;
   localparam logic [9:0] LAST_SLOT = 10'(TotalSlots - 1);

   logic [8:0] slot_ff, slot_in;
   logic [4:0] lip_ff, lip_in;
   logic [4:0] pkt_ff, pkt_in;
   logic [4:0] lip_inc;
   logic       last_slot;
   logic       full;

   // Accept whenever the queue has room
   assign req_ready = !q_full;
   assign push = req_valid && req_ready;

   // Classify the item against the current counters
   always_comb begin
      last_slot = {1'b0, slot_ff} >= LAST_SLOT;
      lip_inc = lip_ff + 5'd1;
      full = lip_inc >= LEDS_PER_PKT;

      job.red = req_red;
      job.green = req_green;
      job.blue = req_blue;
      job.open_pkt = (lip_ff == 5'd0);
      job.ctrl_byte = {3'b000, pkt_ff} | VIDEO_TYPE | (last_slot ? FINAL_BIT : 8'h00);
      job.base_off = {lip_ff, 1'b0} + {1'b0, lip_ff} + 6'd1;
      job.pad = last_slot || full;
      job.last_slot = last_slot;

      // Advance counters, wrap at frame end
      if (last_slot) begin
         slot_in = '0;
         lip_in = '0;
         pkt_in = '0;
      end else begin
         slot_in = slot_ff + 9'd1;
         lip_in = full ? 5'd0 : lip_inc;
         pkt_in = full ? pkt_ff + 5'd1 : pkt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         lip_ff <= '0;
         pkt_ff <= '0;
      end else if (push) begin
         slot_ff <= slot_in;
         lip_ff <= lip_in;
         pkt_ff <= pkt_in;
      end
   end

endmodule

`default_nettype wire

[sv/lvf_queue.sv]
// ============================================================================
// lvf_queue
// Short first-word-fall-through job queue between front and back.
// ============================================================================
`default_nettype none

module lvf_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lvf_pkg::lvf_job_type push_job,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      head_valid,
   output lvf_pkg::lvf_job_type      head_job
);
   import lvf_pkg::*;

   lvf_job_type mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;

   assign full = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job = mem_ff[rd_ptr_ff];

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

[sv/lvf_back.sv]
// ============================================================================
// lvf_back
// Walks the head job byte by byte: control byte when it opens a packet, red,
// green, blue, then zero padding when it closes one early, into a registered output stage.
// ============================================================================
`default_nettype none

module lvf_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire lvf_pkg::lvf_job_type head_job,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [7:0]                rsp_packet_byte,
   output logic [5:0]                rsp_byte_offset,
   output logic                      rsp_packet_done,
   output logic                      rsp_frame_done,
   output logic                      rsp_run_last
);
   import lvf_pkg::*;

   typedef enum logic [2:0] {
      PH_CTRL,
      PH_RED,
      PH_GREEN,
      PH_BLUE,
      PH_PAD
   } phase_type;

   phase_type  phase_ff, phase_in, cur_phase;
   logic       started_ff;
   logic [5:0] off_ff, off_in, cur_off;
   logic       rsp_valid_ff;
   logic [7:0] byte_ff, byte_in;
   logic [5:0] offset_ff, offset_in;
   logic       pdone_ff, pdone_in;
   logic       fdone_ff, fdone_in;
   logic       last_ff, last_in;
   logic       at_end;
   logic       emit;

   assign emit = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop = emit && last_in;

   // Select the next byte of the head job
   always_comb begin
      cur_phase = started_ff ? phase_ff : (head_job.open_pkt ? PH_CTRL : PH_RED);
      cur_off = started_ff ? off_ff : head_job.base_off;
      at_end = (cur_off == LAST_OFFSET);

      byte_in = PAD_BYTE;
      offset_in = cur_off;
      pdone_in = 1'b0;
      fdone_in = 1'b0;
      last_in = 1'b0;
      phase_in = PH_PAD;
      off_in = cur_off + 6'd1;

      case (cur_phase)
         PH_CTRL: begin
            byte_in = head_job.ctrl_byte;
            offset_in = '0;
            phase_in = PH_RED;
            off_in = cur_off;
         end
         PH_RED: begin
            byte_in = head_job.red;
            phase_in = PH_GREEN;
         end
         PH_GREEN: begin
            byte_in = head_job.green;
            phase_in = PH_BLUE;
         end
         PH_BLUE: begin
            byte_in = head_job.blue;
            last_in = !head_job.pad || at_end;
            pdone_in = head_job.pad && at_end;
            fdone_in = head_job.last_slot && at_end;
         end
         PH_PAD: begin
            last_in = at_end;
            pdone_in = at_end;
            fdone_in = head_job.last_slot && at_end;
         end
         default: begin
            last_in = 1'b1;
         end
      endcase
   end

   // Hold sequencer state and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         started_ff <= 1'b0;
         phase_ff <= PH_CTRL;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            byte_ff <= byte_in;
            offset_ff <= offset_in;
            pdone_ff <= pdone_in;
            fdone_ff <= fdone_in;
            last_ff <= last_in;
            started_ff <= !last_in;
            phase_ff <= phase_in;
            off_ff <= off_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_packet_byte = byte_ff;
   assign rsp_byte_offset = offset_ff;
   assign rsp_packet_done = pdone_ff;
   assign rsp_frame_done = fdone_ff;
   assign rsp_run_last = last_ff;

endmodule

`default_nettype wire

[sv/led_video_usb_packet_framer_core.sv]
// ============================================================================
// led_video_usb_packet_framer_core
// Frames LED colours into 64-byte USB video packets, one byte per item out.
//
//   channel  direction  payload
//   req_     in         red, green, blue of the next LED slot
//   rsp_     out        packet_byte, byte_offset, packet_done, frame_done,
//                       run_last
//
// Each LED yields red, green and blue bytes, preceded by a control byte when it opens a
// packet, plus pad bytes at frame end; the single-byte output register sets the rate.
// The queue holds four LEDs, the one being emitted included, so req_ready
// only drops when it fills. Reset clears all counters to the frame start.
// ============================================================================
`default_nettype none

module led_video_usb_packet_framer_core #(
   parameter int STRIP_COUNT = 8,
   parameter int STRIP_LENGTH = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_packet_byte,
   output logic [5:0]      rsp_byte_offset,
   output logic            rsp_packet_done,
   output logic            rsp_frame_done,
   output logic            rsp_run_last
);
   import lvf_pkg::*;

   lvf_job_type push_job;
   lvf_job_type head_job;
   logic        push;
   logic        pop;
   logic        q_full;
   logic        head_valid;

   // Classify incoming LEDs
   lvf_front #(
      .STRIP_COUNT (STRIP_COUNT),
      .STRIP_LENGTH(STRIP_LENGTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_red  (req_red),
      .req_green(req_green),
      .req_blue (req_blue),
      .q_full   (q_full),
      .push     (push),
      .job      (push_job)
   );

   // Decouple front and back
   lvf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (q_full),
      .head_valid(head_valid),
      .head_job  (head_job)
   );

   // Emit packet bytes
   lvf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_packet_byte(rsp_packet_byte),
      .rsp_byte_offset(rsp_byte_offset),
      .rsp_packet_done(rsp_packet_done),
      .rsp_frame_done (rsp_frame_done),
      .rsp_run_last   (rsp_run_last)
   );

`ifndef NO_ASSERTIONS
   a_frame_closes_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_packet_done && rsp_run_last)
      else $error("frame end without packet end");

   a_packet_done_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_done |-> rsp_byte_offset == LAST_OFFSET)
      else $error("packet closed before last offset");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_run_last |=> rsp_valid)
      else $error("gap inside the bytes of one item");

   a_offset_advances: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_run_last |=>
         rsp_byte_offset == $past(rsp_byte_offset) + 6'd1)
      else $error("byte offset did not advance within an item");
`endif

endmodule

`default_nettype wire
